// File: sv/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the stopwatch / countdown timer: action
// codes, slot layout, transaction payloads and the core result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  localparam int SLOT_COUNT = 3;
  localparam logic [1:0] SLOT_LAST = 2'(SLOT_COUNT - 1);

  localparam logic [3:0] ACT_TICK       = 4'd0;
  localparam logic [3:0] ACT_START      = 4'd1;
  localparam logic [3:0] ACT_STOP       = 4'd2;
  localparam logic [3:0] ACT_RESUME     = 4'd3;
  localparam logic [3:0] ACT_CLEAR      = 4'd4;
  localparam logic [3:0] ACT_SAVE       = 4'd5;
  localparam logic [3:0] ACT_INC_HOUR   = 4'd6;
  localparam logic [3:0] ACT_INC_MIN    = 4'd7;
  localparam logic [3:0] ACT_INC_SEC    = 4'd8;
  localparam logic [3:0] ACT_READ       = 4'd9;
  localparam logic [3:0] ACT_NEXT_HIST  = 4'd10;
  localparam logic [3:0] ACT_REWIND     = 4'd11;

  // floor(ticks * 39 / 100) == (ticks * HUND_MUL) >> HUND_SHIFT for 8-bit ticks
  localparam logic [17:0] HUND_MUL   = 18'd204477;
  localparam int          HUND_SHIFT = 19;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] ticks;
  } slot_t;

  typedef struct packed {
    logic [3:0] action;
    logic [1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] ticks;
    logic [6:0] hundredths;
    logic       expired;
    logic [1:0] slot_index;
    logic       running;
  } out_item_t;

  typedef struct packed {
    slot_t      view;
    logic       expired;
    logic [1:0] slot_index;
    logic       running;
  } core_res_t;

endpackage

`default_nettype wire

// File: sv/stc_core.sv
// ----------------------------------------------------------------------------
// stc_core
// Timer state: time slots, run and halt flags, save and history cursors and
// the count mode register. Applies one action per go cycle and returns the
// viewed slot after the action.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_core
  import stc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data,
  input  wire logic      go,
  input  wire in_item_t  item,
  output core_res_t      res
);

  slot_t      slots [SLOT_COUNT];
  slot_t      slots_next [SLOT_COUNT];
  logic       count_mode;
  logic       running;
  logic       running_next;
  logic       halted;
  logic       halted_next;
  logic [1:0] save_cursor;
  logic [1:0] save_cursor_next;
  logic [1:0] history_cursor;
  logic [1:0] history_cursor_next;

  function automatic logic [1:0] cursor_pick(input logic [1:0] cur);
    logic [1:0] v;
    v = cur;
    if (v == 2'd0 || v > SLOT_LAST) begin
      v = 2'd1;
    end
    return v;
  endfunction

  function automatic logic [6:0] hour_wrap24(input logic [6:0] h);
    logic [7:0] v;
    v = {1'b0, h} + 8'd1;
    priority if (v >= 8'd96) begin
      v = v - 8'd96;
    end else if (v >= 8'd72) begin
      v = v - 8'd72;
    end else if (v >= 8'd48) begin
      v = v - 8'd48;
    end else if (v >= 8'd24) begin
      v = v - 8'd24;
    end
    return v[6:0];
  endfunction

  function automatic logic [5:0] inc60(input logic [5:0] v);
    return (v == 6'd59) ? 6'd0 : v + 6'd1;
  endfunction

  always_comb begin
    slot_t      live;
    logic [1:0] idx;
    logic [1:0] view;
    logic       expired;
    slot_t      sel;

    slots_next          = slots;
    running_next        = running;
    halted_next         = halted;
    save_cursor_next    = save_cursor;
    history_cursor_next = history_cursor;
    live    = slots[0];
    idx     = 2'd0;
    view    = 2'd0;
    expired = 1'b0;

    unique case (item.action)
      ACT_TICK: begin
        if (running) begin
          if (!count_mode) begin
            slots_next[0].ticks = live.ticks + 8'd1;
            if (live.ticks == 8'd255) begin
              slots_next[0].seconds = inc60(live.seconds);
              if (live.seconds == 6'd59) begin
                slots_next[0].minutes = inc60(live.minutes);
                if (live.minutes == 6'd59) begin
                  slots_next[0].hours = hour_wrap24(live.hours);
                end
              end
            end
          end else if (!halted) begin
            if (live == '0) begin
              halted_next = 1'b1;
              expired     = 1'b1;
            end else if (live.ticks != 8'd0) begin
              slots_next[0].ticks = live.ticks - 8'd1;
            end else begin
              slots_next[0].ticks = 8'd255;
              if (live.seconds != 6'd0) begin
                slots_next[0].seconds = live.seconds - 6'd1;
              end else begin
                slots_next[0].seconds = 6'd59;
                if (live.minutes != 6'd0) begin
                  slots_next[0].minutes = live.minutes - 6'd1;
                end else begin
                  slots_next[0].minutes = 6'd59;
                  if (live.hours != 7'd0) begin
                    slots_next[0].hours = live.hours - 7'd1;
                  end
                end
              end
            end
          end
        end
      end
      ACT_START: begin
        halted_next  = 1'b0;
        running_next = 1'b1;
      end
      ACT_STOP: begin
        running_next = 1'b0;
      end
      ACT_RESUME: begin
        running_next = 1'b1;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slots_next[i] = '0;
        end
        running_next        = 1'b0;
        halted_next         = 1'b1;
        save_cursor_next    = 2'd1;
        history_cursor_next = 2'd1;
      end
      ACT_SAVE: begin
        idx              = cursor_pick(save_cursor);
        save_cursor_next = idx + 2'd1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (idx == 2'(i)) begin
            slots_next[i] = live;
          end
        end
      end
      ACT_INC_HOUR: begin
        view = item.slot;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (item.slot == 2'(i)) begin
            slots_next[i].hours = (slots[i].hours == 7'd99) ? 7'd0 : slots[i].hours + 7'd1;
          end
        end
      end
      ACT_INC_MIN: begin
        view = item.slot;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (item.slot == 2'(i)) begin
            slots_next[i].minutes = inc60(slots[i].minutes);
          end
        end
      end
      ACT_INC_SEC: begin
        view = item.slot;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (item.slot == 2'(i)) begin
            slots_next[i].seconds = inc60(slots[i].seconds);
          end
        end
      end
      ACT_READ: begin
        view = item.slot;
      end
      ACT_NEXT_HIST: begin
        idx                 = cursor_pick(history_cursor);
        history_cursor_next = idx + 2'd1;
        view                = idx;
      end
      ACT_REWIND: begin
        history_cursor_next = 2'd1;
      end
      default: begin
      end
    endcase

    // out-of-range view shows zeros
    sel = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (view == 2'(i)) begin
        sel = slots_next[i];
      end
    end

    res.view       = sel;
    res.expired    = expired;
    res.slot_index = idx;
    res.running    = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
      count_mode     <= 1'b1;
      running        <= 1'b0;
      halted         <= 1'b1;
      save_cursor    <= 2'd1;
      history_cursor <= 2'd1;
    end else begin
      if (cfg_wr_en) begin
        count_mode <= cfg_wr_data;
      end
      if (go) begin
        slots          <= slots_next;
        running        <= running_next;
        halted         <= halted_next;
        save_cursor    <= save_cursor_next;
        history_cursor <= history_cursor_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/stc_view.sv
// ----------------------------------------------------------------------------
// stc_view
// Formats the core result into an output transaction, converting ticks to
// hundredths by a constant reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_view
  import stc_pkg::*;
(
  input  wire core_res_t res,
  output out_item_t      out_item
);

  logic [25:0] prod;

  assign prod = 26'(res.view.ticks) * 26'(HUND_MUL);

  always_comb begin
    out_item.hours      = res.view.hours;
    out_item.minutes    = res.view.minutes;
    out_item.seconds    = res.view.seconds;
    out_item.ticks      = res.view.ticks;
    out_item.hundredths = prod[HUND_SHIFT +: 7];
    out_item.expired    = res.expired;
    out_item.slot_index = res.slot_index;
    out_item.running    = res.running;
  end

endmodule

`default_nettype wire

// File: sv/stopwatch_countdown_timer_top.sv
// ----------------------------------------------------------------------------
// stopwatch_countdown_timer_top
// Stopwatch / countdown timer with lap slots, one action per transaction.
//
// Input channel: in_valid / in_stall / in_data (action, slot). An action is
// taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall / out_data, one result transaction
// for every input transaction, in order.
// Config: cfg_wr_en / cfg_wr_data write count_mode (0 up, 1 down); write
// only while no transaction is in flight.
// Path: an accepted action goes into the input register, then through a
// single-pass update into the result register that drives out_valid.
// Throughput: one transaction per cycle while out_stall stays low.
// Reset: clears all slots, stops the timer, halts the countdown, sets both
// cursors to 1 and count_mode to down.
// Stall: while out_stall holds a result, one more transaction is taken into
// the input register; after that in_stall rises until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module stopwatch_countdown_timer_top
  import stc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      in_q_valid;
  in_item_t  in_q;
  logic      advance;
  logic      go;
  core_res_t res;
  out_item_t out_item;

  assign advance  = !out_valid || !out_stall;
  assign go       = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (go) begin
      out_data <= out_item;
    end
  end

  stc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .item        (in_q),
    .res         (res)
  );

  stc_view u_view (
    .res      (res),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
